FILE: src/arm_safety_supervisor_macros.svh
// assertion macros used by the supervisor core
`ifndef ARM_SAFETY_SUPERVISOR_MACROS_SVH
`define ARM_SAFETY_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF

// clocked property, masked while reset is asserted
`define ASV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("supervisor assertion failed");

// same, with a caller supplied message
`define ASV_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`else

`define ASV_ASSERT(lbl, prop)
`define ASV_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

FILE: src/asv_pkg.sv
`default_nettype none

package asv_pkg;

	localparam int TIME_BITS_DEF = 32;

	// operation codes
	localparam logic [2:0] OP_HELLO    = 3'd0;
	localparam logic [2:0] OP_COMMAND  = 3'd1;
	localparam logic [2:0] OP_FEEDBACK = 3'd2;
	localparam logic [2:0] OP_MODE     = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	// modes
	localparam logic [1:0] MODE_WAIT_LINK = 2'd0;
	localparam logic [1:0] MODE_DISARMED  = 2'd1;
	localparam logic [1:0] MODE_ACTIVE    = 2'd2;
	localparam logic [1:0] MODE_SAFE      = 2'd3;

	// mode requests
	localparam logic [1:0] REQ_DISARM = 2'd0;
	localparam logic [1:0] REQ_ARM    = 2'd1;

	// latched fault codes
	localparam logic [2:0] FAULT_NONE             = 3'd0;
	localparam logic [2:0] FAULT_STALE_NO_COMMAND = 3'd1;
	localparam logic [2:0] FAULT_STALE            = 3'd2;
	localparam logic [2:0] FAULT_BAD_HELLO        = 3'd3;
	localparam logic [2:0] FAULT_BAD_MODE         = 3'd4;
	localparam logic [2:0] FAULT_BAD_COMMAND      = 3'd5;
	localparam logic [2:0] FAULT_BAD_FEEDBACK     = 3'd6;

	localparam logic [7:0] HELLO_MIN_LENGTH = 8'd10;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_CMD_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_FB_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_PEER_ROLE   = 2'd2;
	localparam logic [1:0] REG_VERSION     = 2'd3;

	localparam logic [15:0] CMD_TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] FB_TIMEOUT_RESET  = 16'd50;
	localparam logic [7:0]  PEER_ROLE_RESET   = 8'd0;
	localparam logic [7:0]  VERSION_RESET     = 8'd0;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] now_ms;
		logic        payload_valid;
		logic [7:0]  hello_length;
		logic [7:0]  hello_role;
		logic [7:0]  hello_version;
		logic [1:0]  mode_request;
		logic [31:0] transaction_id;
	} item_t;

	typedef struct packed {
		logic [15:0] command_timeout_ms;
		logic [15:0] feedback_timeout_ms;
		logic [7:0]  expected_peer_role;
		logic [7:0]  expected_version;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode_now;
		logic [2:0]  fault_now;
		logic        ack_valid;
		logic        ack_rejected;
		logic [31:0] ack_transaction;
		logic        effort_enable;
	} result_t;

endpackage

`default_nettype wire

FILE: src/asv_cfg.sv
`default_nettype none

module asv_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	output asv_pkg::cfg_t cfg
);
	import asv_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_timeout_ms  <= CMD_TIMEOUT_RESET;
			cfg_q.feedback_timeout_ms <= FB_TIMEOUT_RESET;
			cfg_q.expected_peer_role  <= PEER_ROLE_RESET;
			cfg_q.expected_version    <= VERSION_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CMD_TIMEOUT: cfg_q.command_timeout_ms  <= pwdata[15:0];
				REG_FB_TIMEOUT:  cfg_q.feedback_timeout_ms <= pwdata[15:0];
				REG_PEER_ROLE:   cfg_q.expected_peer_role  <= pwdata[7:0];
				REG_VERSION:     cfg_q.expected_version    <= pwdata[7:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CMD_TIMEOUT: prdata = {16'd0, cfg_q.command_timeout_ms};
			REG_FB_TIMEOUT:  prdata = {16'd0, cfg_q.feedback_timeout_ms};
			REG_PEER_ROLE:   prdata = {24'd0, cfg_q.expected_peer_role};
			REG_VERSION:     prdata = {24'd0, cfg_q.expected_version};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/asv_core.sv
`default_nettype none
`include "arm_safety_supervisor_macros.svh"

module asv_core #(
	parameter int TIME_BITS = asv_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  asv_pkg::item_t   item,
	input  asv_pkg::cfg_t    cfg,
	output asv_pkg::result_t res
);
	import asv_pkg::*;

	// supervisor state
	logic [1:0]           mode_q;
	logic [2:0]           fault_q;
	logic                 link_q;
	logic                 have_cmd_q;
	logic                 have_fb_q;
	logic [TIME_BITS-1:0] cmd_time_q;
	logic [TIME_BITS-1:0] fb_time_q;

	logic [1:0]           mode_d;
	logic [2:0]           fault_d;
	logic                 link_d;
	logic                 have_cmd_d;
	logic                 have_fb_d;
	logic [TIME_BITS-1:0] cmd_time_d;
	logic [TIME_BITS-1:0] fb_time_d;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] cmd_age;
	logic [TIME_BITS-1:0] fb_age;
	logic                 fresh;
	logic                 bad_hello;

	// time kept modulo 2^TIME_BITS
	assign now_t   = TIME_BITS'({32'd0, item.now_ms});
	assign cmd_age = now_t - cmd_time_q;
	assign fb_age  = now_t - fb_time_q;
	assign fresh   = have_cmd_q & have_fb_q
		& (cmd_age <= TIME_BITS'(cfg.command_timeout_ms))
		& (fb_age <= TIME_BITS'(cfg.feedback_timeout_ms));

	assign bad_hello = (item.hello_length < HELLO_MIN_LENGTH)
		| (item.hello_role != cfg.expected_peer_role)
		| (item.hello_version != cfg.expected_version);

	always_comb begin
		mode_d     = mode_q;
		fault_d    = fault_q;
		link_d     = link_q;
		have_cmd_d = have_cmd_q;
		have_fb_d  = have_fb_q;
		cmd_time_d = cmd_time_q;
		fb_time_d  = fb_time_q;
		res.ack_valid       = 1'b0;
		res.ack_rejected    = 1'b0;
		res.ack_transaction = 32'd0;
		res.effort_enable   = 1'b0;
		unique case (item.operation)
			OP_HELLO: begin
				if (bad_hello) begin
					fault_d = FAULT_BAD_HELLO;
				end else begin
					link_d = 1'b1;
					if (mode_q == MODE_WAIT_LINK) begin
						mode_d = MODE_DISARMED;
					end
				end
			end
			OP_COMMAND: begin
				if (item.payload_valid) begin
					cmd_time_d = now_t;
					have_cmd_d = 1'b1;
				end else begin
					fault_d = FAULT_BAD_COMMAND;
				end
			end
			OP_FEEDBACK: begin
				if (item.payload_valid) begin
					fb_time_d = now_t;
					have_fb_d = 1'b1;
				end else begin
					fault_d = FAULT_BAD_FEEDBACK;
				end
			end
			OP_MODE: begin
				if (!item.payload_valid) begin
					fault_d = FAULT_BAD_MODE;
				end else begin
					res.ack_valid       = 1'b1;
					res.ack_transaction = item.transaction_id;
					priority if (item.mode_request == REQ_DISARM) begin
						mode_d = MODE_DISARMED;
					end else if (item.mode_request == REQ_ARM && link_q && fresh
						&& fault_q == FAULT_NONE) begin
						mode_d = MODE_ACTIVE;
					end else begin
						mode_d           = MODE_SAFE;
						res.ack_rejected = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (mode_q == MODE_ACTIVE) begin
					if (fresh) begin
						res.effort_enable = 1'b1;
					end else begin
						mode_d  = MODE_SAFE;
						fault_d = have_cmd_q ? FAULT_STALE : FAULT_STALE_NO_COMMAND;
					end
				end
			end
			default: ;
		endcase
		res.mode_now  = mode_d;
		res.fault_now = fault_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_WAIT_LINK;
			fault_q    <= FAULT_NONE;
			link_q     <= 1'b0;
			have_cmd_q <= 1'b0;
			have_fb_q  <= 1'b0;
			cmd_time_q <= '0;
			fb_time_q  <= '0;
		end else if (en) begin
			mode_q     <= mode_d;
			fault_q    <= fault_d;
			link_q     <= link_d;
			have_cmd_q <= have_cmd_d;
			have_fb_q  <= have_fb_d;
			cmd_time_q <= cmd_time_d;
			fb_time_q  <= fb_time_d;
		end
	end

	// effort only ever granted from the active mode
	`ASV_ASSERT(a_effort_active, res.effort_enable |-> mode_q == MODE_ACTIVE)
	// a stale tick in active mode forces safe
	`ASV_ASSERT(a_stale_safe, en && item.operation == OP_TICK && mode_q == MODE_ACTIVE && !fresh |=> mode_q == MODE_SAFE)
	// faults only clear on reset
	`ASV_ASSERT_MSG(a_fault_sticky, fault_q != FAULT_NONE |=> fault_q != FAULT_NONE, "fault cleared")
	// link once seen stays seen
	`ASV_ASSERT_MSG(a_link_sticky, link_q |=> link_q, "link flag dropped")

endmodule

`default_nettype wire

FILE: src/arm_safety_supervisor.sv
// arm safety supervisor
// s_* : event stream in; s_tuser carries the operation code, s_tdata the
//       timestamp, payload flag, hello bytes, mode request and transaction
// m_* : one result beat per event: mode, latched fault, mode ack and the
//       effort enable that answers a control tick
// apb : four registers at 0x0, 0x4, 0x8, 0xc (command timeout, feedback
//       timeout, expected peer role, expected version); pready is tied high
// path: an event beat lands in the input register; its result is then
//       computed from the supervisor state and loaded into the output
//       register, which drives m_tvalid
// throughput: one event per cycle while m_tready is high; the state
//       update and the result load share one clock edge, so each event
//       sees the state its predecessor left behind
// stall: when m_tready is low the output register holds its beat; the
//       input register still takes one more beat, and s_tready then falls
//       until the output drains
// reset: arst_n clears both pipeline valids, returns the mode to wait link,
//       clears the fault, flags and timestamps and reloads the register
//       defaults (100, 50, 0, 0)
`default_nettype none

module arm_safety_supervisor #(
	parameter int TIME_BITS = asv_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// event stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	// [31:0] now_ms, [32] payload_valid, [40:33] hello_length,
	// [48:41] hello_role, [56:49] hello_version, [58:57] mode_request,
	// [90:59] transaction_id, [95:91] zero
	input  logic [95:0] s_tdata,
	// [2:0] operation
	input  logic [2:0]  s_tuser,
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] mode_now, [4:2] fault_now, [5] ack_valid, [6] ack_rejected,
	// [38:7] ack_transaction, [39] effort_enable
	output logic [39:0] m_tdata,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import asv_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    s_beat;

	// the event in stage one moves on when the output slot is free or emptying
	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign s_beat   = s_tvalid & s_tready;

	asv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_beat) begin
			item_s1.operation      <= s_tuser;
			item_s1.now_ms         <= s_tdata[31:0];
			item_s1.payload_valid  <= s_tdata[32];
			item_s1.hello_length   <= s_tdata[40:33];
			item_s1.hello_role     <= s_tdata[48:41];
			item_s1.hello_version  <= s_tdata[56:49];
			item_s1.mode_request   <= s_tdata[58:57];
			item_s1.transaction_id <= s_tdata[90:59];
		end
	end

	// state and decision logic; state commits on the same edge as the result
	asv_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.effort_enable, res_s2.ack_transaction, res_s2.ack_rejected,
		res_s2.ack_valid, res_s2.fault_now, res_s2.mode_now};

endmodule

`default_nettype wire

FILE: sim/tb_arm_safety_supervisor.sv
`default_nettype none

module tb_arm_safety_supervisor;
	import asv_pkg::*;

	// codes the block must ignore or reject, named for the stimulus
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam logic [1:0] REQ_OTHER = 2'd2;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	arm_safety_supervisor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// supervisor state as the testbench sees it
	logic [1:0]  sv_mode;
	logic [2:0]  sv_fault;
	logic        link_ok;
	logic        got_cmd;
	logic        got_fb;
	logic [31:0] cmd_stamp;
	logic [31:0] fb_stamp;
	logic [15:0] cfg_cmd_to;
	logic [15:0] cfg_fb_to;
	logic [7:0]  cfg_role;
	logic [7:0]  cfg_ver;

	result_t     pending_status[$];
	result_t     want_status;

	int tx_max_gap = 17;
	int rx_max_gap = 17;
	int rx_stall = 0;
	int rx_hold_cycles = 0;
	int cycle_count = 0;
	int events_sent = 0;
	int beats_checked = 0;
	int settings_used = 0;
	int mismatches = 0;
	logic [31:0] steady_clock;
	logic [31:0] noise_clock;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("tb_arm_safety_supervisor NOT OK");
		$finish;
	end

	function automatic logic age_ok(logic [31:0] now, logic [31:0] stamp, logic [15:0] limit);
		logic [31:0] age;
		age = now - stamp;
		return age <= {16'd0, limit};
	endfunction

	// advances the supervisor state by one event and returns its status beat
	function automatic result_t predict_status(item_t ev);
		result_t r;
		logic    fresh;
		r = '0;
		fresh = got_cmd && got_fb && age_ok(ev.now_ms, cmd_stamp, cfg_cmd_to) &&
			age_ok(ev.now_ms, fb_stamp, cfg_fb_to);
		case (ev.operation)
			OP_HELLO: begin
				if (ev.hello_length < HELLO_MIN_LENGTH || ev.hello_role != cfg_role ||
						ev.hello_version != cfg_ver) begin
					sv_fault = FAULT_BAD_HELLO;
				end else begin
					link_ok = 1'b1;
					if (sv_mode == MODE_WAIT_LINK) sv_mode = MODE_DISARMED;
				end
			end
			OP_COMMAND: begin
				if (ev.payload_valid) begin
					cmd_stamp = ev.now_ms;
					got_cmd = 1'b1;
				end else begin
					sv_fault = FAULT_BAD_COMMAND;
				end
			end
			OP_FEEDBACK: begin
				if (ev.payload_valid) begin
					fb_stamp = ev.now_ms;
					got_fb = 1'b1;
				end else begin
					sv_fault = FAULT_BAD_FEEDBACK;
				end
			end
			OP_MODE: begin
				if (!ev.payload_valid) begin
					sv_fault = FAULT_BAD_MODE;
				end else begin
					r.ack_valid = 1'b1;
					r.ack_transaction = ev.transaction_id;
					if (ev.mode_request == REQ_DISARM) begin
						sv_mode = MODE_DISARMED;
					end else if (ev.mode_request == REQ_ARM && link_ok && fresh &&
							sv_fault == FAULT_NONE) begin
						sv_mode = MODE_ACTIVE;
					end else begin
						sv_mode = MODE_SAFE;
						r.ack_rejected = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (sv_mode == MODE_ACTIVE) begin
					if (fresh) begin
						r.effort_enable = 1'b1;
					end else begin
						sv_mode = MODE_SAFE;
						sv_fault = got_cmd ? FAULT_STALE : FAULT_STALE_NO_COMMAND;
					end
				end
			end
			default: ;
		endcase
		r.mode_now = sv_mode;
		r.fault_now = sv_fault;
		return r;
	endfunction

	function automatic item_t mk_event(logic [2:0] op, logic [31:0] now, logic pv,
			logic [7:0] hlen, logic [7:0] role, logic [7:0] ver, logic [1:0] req,
			logic [31:0] txn);
		item_t ev;
		ev.operation = op;
		ev.now_ms = now;
		ev.payload_valid = pv;
		ev.hello_length = hlen;
		ev.hello_role = role;
		ev.hello_version = ver;
		ev.mode_request = req;
		ev.transaction_id = txn;
		return ev;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// one event beat; valid is left high so a back-to-back beat needs no glitch
	task automatic send_event(input item_t ev);
		int gap;
		gap = $urandom_range(tx_max_gap, 0);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser = ev.operation;
		s_tdata = {5'd0, ev.transaction_id, ev.mode_request, ev.hello_version, ev.hello_role,
			ev.hello_length, ev.payload_valid, ev.now_ms};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_status.push_back(predict_status(ev));
		events_sent++;
	endtask

	// drop valid and wait until every expected beat has come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// writes all four registers while idle, then reads them back
	task automatic set_limits(input logic [15:0] cmd_to, input logic [15:0] fb_to,
			input logic [7:0] role, input logic [7:0] ver);
		logic [31:0] val [4];
		logic [31:0] rd;
		val[REG_CMD_TIMEOUT] = {16'd0, cmd_to};
		val[REG_FB_TIMEOUT] = {16'd0, fb_to};
		val[REG_PEER_ROLE] = {24'd0, role};
		val[REG_VERSION] = {24'd0, ver};
		wait_drained();
		for (int i = 0; i < 4; i++) apb_access(1'b1, 2'(i), val[i], rd);
		cfg_cmd_to = cmd_to;
		cfg_fb_to = fb_to;
		cfg_role = role;
		cfg_ver = ver;
		for (int i = 0; i < 4; i++) begin
			apb_access(1'b0, 2'(i), 32'd0, rd);
			check_field("register readback", val[i], rd);
		end
		settings_used++;
	endtask

	// receiver: per-beat stall drawn by the checker, long hold counted here
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready = 1'b0;
				rx_hold_cycles--;
			end else if (rx_stall > 0) begin
				m_tready = 1'b0;
				rx_stall--;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// checker: every result beat against the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_status.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				want_status = pending_status.pop_front();
				check_field("mode_now", 32'(want_status.mode_now), 32'(m_tdata[1:0]));
				check_field("fault_now", 32'(want_status.fault_now), 32'(m_tdata[4:2]));
				check_field("ack_valid", 32'(want_status.ack_valid), 32'(m_tdata[5]));
				check_field("ack_rejected", 32'(want_status.ack_rejected), 32'(m_tdata[6]));
				check_field("ack_transaction", want_status.ack_transaction, m_tdata[38:7]);
				check_field("effort_enable", 32'(want_status.effort_enable), 32'(m_tdata[39]));
			end
			beats_checked++;
			rx_stall = $urandom_range(rx_max_gap, 0);
		end
	end

	task automatic test_register_defaults();
		logic [31:0] rd;
		apb_access(1'b0, REG_CMD_TIMEOUT, 32'd0, rd);
		check_field("command timeout default", {16'd0, CMD_TIMEOUT_RESET}, rd);
		apb_access(1'b0, REG_FB_TIMEOUT, 32'd0, rd);
		check_field("feedback timeout default", {16'd0, FB_TIMEOUT_RESET}, rd);
		apb_access(1'b0, REG_PEER_ROLE, 32'd0, rd);
		check_field("peer role default", {24'd0, PEER_ROLE_RESET}, rd);
		apb_access(1'b0, REG_VERSION, 32'd0, rd);
		check_field("version default", {24'd0, VERSION_RESET}, rd);
	endtask

	// link-up, arming across a time wrap, freshness at the limit, ignored codes
	task automatic test_link_and_arm();
		set_limits(16'd100, 16'd50, 8'hA5, 8'h5A);
		send_event(mk_event(OP_TICK, 32'd5, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_HELLO, 32'd5, 1'b0, HELLO_MIN_LENGTH, 8'hA5, 8'h5A, REQ_DISARM,
			32'd0));
		send_event(mk_event(OP_MODE, 32'd6, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hFFFF_FFFF));
		send_event(mk_event(OP_MODE, 32'd6, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_COMMAND, 32'hFFFF_FFC0, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd1));
		send_event(mk_event(OP_FEEDBACK, 32'hFFFF_FFF0, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd2));
		// feedback exactly 50 ms old after the wrap still counts as fresh
		send_event(mk_event(OP_MODE, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'h1234_5678));
		send_event(mk_event(OP_TICK, 32'h22, 1'b1, 8'hFF, 8'hFF, 8'hFF, REQ_SPARE, 32'hFFFF_FFFF));
		send_event(mk_event(OP_SPARE5, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'd7));
		send_event(mk_event(OP_MODE, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_OTHER, 32'hA5A5_0001));
		send_event(mk_event(OP_MODE, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hA5A5_0002));
		send_event(mk_event(OP_MODE, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_SPARE, 32'hA5A5_0003));
		send_event(mk_event(OP_MODE, 32'h22, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hA5A5_0004));
		send_event(mk_event(OP_SPARE6, 32'h22, 1'b0, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_SPARE7, 32'hFFFF_FFFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, REQ_SPARE,
			32'hFFFF_FFFF));
	endtask

	// well-formed traffic with a steadily advancing clock, mostly keeping the link armed
	task automatic run_steady(input int count, input int max_step);
		int          roll;
		logic [2:0]  op;
		logic [1:0]  req;
		for (int i = 0; i < count; i++) begin
			case ((i / 40) % 4)
				0: begin tx_max_gap = 17; rx_max_gap = 17; end
				1: begin tx_max_gap = 0; rx_max_gap = 0; end
				2: begin tx_max_gap = 0; rx_max_gap = 17; end
				default: begin tx_max_gap = 17; rx_max_gap = 0; end
			endcase
			steady_clock = steady_clock + 32'($urandom_range(max_step, 0));
			roll = $urandom_range(99, 0);
			if (roll < 30) op = OP_COMMAND;
			else if (roll < 60) op = OP_FEEDBACK;
			else if (roll < 85) op = OP_TICK;
			else if (roll < 95) op = OP_MODE;
			else op = OP_HELLO;
			roll = $urandom_range(9, 0);
			req = (roll < 6) ? REQ_ARM : (roll < 8) ? REQ_DISARM : 2'($urandom_range(3, 2));
			send_event(mk_event(op, steady_clock, 1'b1, 8'($urandom_range(255, 10)),
				cfg_role, cfg_ver, req, $urandom));
		end
	endtask

	task automatic test_steady_traffic();
		steady_clock = 32'h40;
		set_limits(16'd400, 16'd300, 8'hA5, 8'h5A);
		send_event(mk_event(OP_HELLO, steady_clock, 1'b1, 8'd200, cfg_role, cfg_ver, REQ_ARM, 32'd0));
		run_steady(160, 8);
		// sender holds off until the pipeline is empty
		wait_drained();
		run_steady(20, 8);
		set_limits(16'd100, 16'd50, 8'hA5, 8'h5A);
		run_steady(140, 5);
	endtask

	// receiver stops for a long while; the block fills and stops taking beats
	task automatic test_output_stall();
		wait_drained();
		@(posedge clk);
		rx_hold_cycles = 300;
		tx_max_gap = 0;
		run_steady(40, 3);
		wait_drained();
	endtask

	task automatic test_fault_latching();
		logic [31:0] t;
		tx_max_gap = 17;
		rx_max_gap = 17;
		t = steady_clock + 32'd1000;
		// stale tick while active latches the stale fault
		send_event(mk_event(OP_COMMAND, t, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_FEEDBACK, t, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_MODE, t, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hC0DE_0001));
		send_event(mk_event(OP_TICK, t + 32'd51, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		// arm refused with a fault latched even though all is fresh
		send_event(mk_event(OP_COMMAND, t + 32'd60, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_FEEDBACK, t + 32'd60, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_MODE, t + 32'd60, 1'b1, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hC0DE_0002));
		send_event(mk_event(OP_MODE, t + 32'd60, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'hC0DE_0003));
		// bad hellos: short, wrong role, wrong version
		send_event(mk_event(OP_HELLO, t, 1'b1, 8'd9, cfg_role, cfg_ver, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_HELLO, t, 1'b1, 8'hFF, ~cfg_role, cfg_ver, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_HELLO, t, 1'b1, 8'd0, cfg_role, cfg_ver, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_HELLO, t, 1'b1, 8'd10, cfg_role, ~cfg_ver, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_COMMAND, t, 1'b0, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_FEEDBACK, t, 1'b0, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
		send_event(mk_event(OP_MODE, t, 1'b0, 8'd0, 8'd0, 8'd0, REQ_ARM, 32'hDEAD_BEEF));
		send_event(mk_event(OP_TICK, t, 1'b1, 8'd0, 8'd0, 8'd0, REQ_DISARM, 32'd0));
	endtask

	// anything goes: broken frames, random clocks, spare codes
	task automatic run_noise(input int count);
		int          done;
		logic [2:0]  op;
		logic [31:0] now;
		done = 0;
		while (done < count) begin
			if (done % 30 == 0) begin
				tx_max_gap = $urandom_range(1, 0) ? 17 : 0;
				rx_max_gap = $urandom_range(1, 0) ? 17 : 0;
			end
			op = 3'($urandom_range(7, 0));
			if ($urandom_range(1, 0)) begin
				now = $urandom;
			end else begin
				noise_clock = noise_clock + 32'($urandom_range(120, 0));
				now = noise_clock;
			end
			send_event(mk_event(op, now, $urandom_range(3, 0) != 0,
				$urandom_range(1, 0) ? 8'($urandom_range(15, 0)) : 8'($urandom_range(255, 0)),
				$urandom_range(1, 0) ? cfg_role : 8'($urandom_range(255, 0)),
				$urandom_range(1, 0) ? cfg_ver : 8'($urandom_range(255, 0)),
				2'($urandom_range(3, 0)), $urandom));
			done++;
		end
	endtask

	task automatic test_random_events();
		noise_clock = $urandom;
		set_limits(16'd0, 16'd0, 8'd0, 8'd0);
		run_noise(60);
		set_limits(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
		run_noise(60);
		set_limits(16'($urandom_range(300, 0)), 16'($urandom_range(300, 0)),
			8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
		run_noise(60);
		set_limits(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		run_noise(60);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sv_mode = MODE_WAIT_LINK;
		sv_fault = FAULT_NONE;
		link_ok = 1'b0;
		got_cmd = 1'b0;
		got_fb = 1'b0;
		cmd_stamp = '0;
		fb_stamp = '0;
		cfg_cmd_to = CMD_TIMEOUT_RESET;
		cfg_fb_to = FB_TIMEOUT_RESET;
		cfg_role = PEER_ROLE_RESET;
		cfg_ver = VERSION_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_link_and_arm();
		test_steady_traffic();
		test_output_stall();
		test_fault_latching();
		test_random_events();
		wait_drained();

		$display("ran %0d events through %0d register settings, %0d result beats checked",
			events_sent, settings_used, beats_checked);
		$display("covered link-up, arming, stale drop to safe, latched faults and output stalls");
		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("tb_arm_safety_supervisor OK");
		end else begin
			$display("tb_arm_safety_supervisor NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
